// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of the translator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is active.
`define CTA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("translator assertion failed");

// Concurrent assertion that also holds during reset.
`define CTA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("translator assertion failed");

`endif

// ===== sv/cta_pkg.sv =====
// Package of the codon translator: widths, character codes, the codon record
// and the standard genetic code table. No dependencies.
package cta_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int CFG_W             = 16;
  localparam int APB_ADDR_W        = 3;
  localparam int APB_DATA_W        = 32;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam logic [CFG_W-1:0] FRAME_START_RESET = 16'd1;

  // Register index of frame_start within the register map.
  localparam logic REG_FRAME_START = 1'b0;

  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_C    = 8'h43;
  localparam logic [7:0] CHAR_G    = 8'h47;
  localparam logic [7:0] CHAR_T    = 8'h54;
  localparam logic [7:0] CHAR_STOP = 8'h58;
  localparam logic [7:0] CHAR_NONE = 8'h00;

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  // Index = 16*b1 + 4*b2 + b3 with A=0, C=1, G=2, T=3; entry 0 is the top byte.
  localparam logic [0:63][7:0] AMINO_TABLE = {
    "KNKNTTTTRSRSIIMI",
    "QHQHPPPPRRRRLLLL",
    "EDEDAAAAGGGGVVVV",
    "XYXYSSSSXCWCLFLF"
  };

  // A complete codon as classified by the front end.
  typedef struct packed {
    logic       known;
    logic       stop;
    logic [5:0] index;
  } codon_t;

  // Base decoder: bit 2 flags a valid uppercase nucleotide, bits 1:0 its code.
  function automatic logic [2:0] base_code(input logic [7:0] ch);
    logic [2:0] res;
    unique case (ch)
      CHAR_A:  res = {1'b1, CODE_A};
      CHAR_C:  res = {1'b1, CODE_C};
      CHAR_G:  res = {1'b1, CODE_G};
      CHAR_T:  res = {1'b1, CODE_T};
      default: res = 3'b000;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] amino_lookup(input logic [5:0] index);
    return AMINO_TABLE[index];
  endfunction

endpackage

// ===== sv/cta_front.sv =====
// Front end of the codon translator: frame skipping, codon assembly and
// classification. Depends on cta_pkg.
module cta_front #(
  parameter int POSITION_BITS = cta_pkg::POSITION_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [7:0]                 base_char_i,
  input  logic                       last_base_i,
  input  logic [cta_pkg::CFG_W-1:0]  frame_start_i,
  input  logic                       queue_full_i,
  output logic                       in_stall_o,
  output logic                       push_o,
  output cta_pkg::codon_t            codon_o
);
  import cta_pkg::*;

  localparam int CmpW = (POSITION_BITS > CFG_W) ? POSITION_BITS : CFG_W;

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [1:0]               phase_q, phase_d;
  logic [7:0]               first_q, first_d;
  logic [7:0]               second_q, second_d;
  logic                     stop_q, stop_d;
  logic                     accept;
  logic [CFG_W-1:0]         skip;
  logic                     skipping;
  logic [2:0]               c1, c2, c3;
  codon_t                   codon;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  // A start position of zero behaves as one.
  assign skip     = (frame_start_i == '0) ? '0 : frame_start_i - CFG_W'(1);
  assign skipping = CmpW'(pos_q) < CmpW'(skip);

  // Classify the codon that the current base would complete.
  assign c1 = base_code(first_q);
  assign c2 = base_code(second_q);
  assign c3 = base_code(base_char_i);
  always_comb begin
    codon.known = c1[2] && c2[2] && c3[2];
    codon.index = {c1[1:0], c2[1:0], c3[1:0]};
    codon.stop  = codon.known && (amino_lookup(codon.index) == CHAR_STOP);
  end

  // Next state of the codon assembler.
  always_comb begin
    pos_d    = pos_q;
    phase_d  = phase_q;
    first_d  = first_q;
    second_d = second_q;
    stop_d   = stop_q;
    push_o   = 1'b0;
    if (accept) begin
      if (skipping) begin
        if (pos_q != {POSITION_BITS{1'b1}}) begin
          pos_d = pos_q + POSITION_BITS'(1);
        end
      end else if (!stop_q) begin
        case (phase_q)
          2'd0: begin
            first_d = base_char_i;
            phase_d = 2'd1;
          end
          2'd1: begin
            second_d = base_char_i;
            phase_d  = 2'd2;
          end
          default: begin
            push_o  = 1'b1;
            phase_d = 2'd0;
            if (codon.stop) begin
              stop_d = 1'b1;
            end
          end
        endcase
      end
      // The final base of a sequence returns everything to reset.
      if (last_base_i) begin
        pos_d    = '0;
        phase_d  = 2'd0;
        first_d  = '0;
        second_d = '0;
        stop_d   = 1'b0;
      end
    end
  end

  assign codon_o = codon;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= 2'd0;
      first_q  <= '0;
      second_q <= '0;
      stop_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      phase_q  <= phase_d;
      first_q  <= first_d;
      second_q <= second_d;
      stop_q   <= stop_d;
    end
  end

endmodule

// ===== sv/cta_queue.sv =====
// Short queue of classified codons between the front and back ends.
// Depends on cta_pkg.
module cta_queue #(
  parameter int DEPTH = cta_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cta_pkg::codon_t push_data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output cta_pkg::codon_t pop_data_o
);
  import cta_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  codon_t              mem_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o     = count_q == CntW'(DEPTH);
  assign valid_o    = count_q != '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update; pointers wrap at the last entry.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== sv/cta_back.sv =====
// Back end of the codon translator: genetic code lookup and the output
// register. Depends on cta_pkg.
module cta_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            queue_valid_i,
  input  cta_pkg::codon_t codon_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      amino_char_o,
  output logic            is_stop_o
);
  import cta_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] amino_q;
  logic       stop_q;

  // Take a codon whenever the output register is empty or being drained.
  assign pop_o = queue_valid_i && (!valid_q || !out_stall_i);

  always_comb begin
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload; a codon with an unknown base translates to zero.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      amino_q <= codon_i.known ? amino_lookup(codon_i.index) : CHAR_NONE;
      stop_q  <= codon_i.stop;
    end
  end

  assign out_valid_o  = valid_q;
  assign amino_char_o = amino_q;
  assign is_stop_o    = stop_q;

endmodule

// ===== sv/codon_to_amino_translator_unit.sv =====
// Top level of the codon translator: register port and the front, queue and
// back instances. Depends on cta_pkg, cta_front, cta_queue and cta_back.
//
// The unit takes one ASCII base per cycle and gives one amino acid letter per
// complete codon, so a sustained stream runs at one base a cycle while the
// input is not stalled; a result appears once it has passed the codon queue
// and then the output register. Input stall rises only while
// the two-entry codon queue is full, which happens when the output side has
// been stalled long enough for the output register and the queue to fill.
// Bases before position frame_start are skipped, a stop codon gives the letter
// X flagged as stop and silences the unit until the last base, and the last
// base of a sequence resets the front end. frame_start sits at byte address 0
// and must be written only while idle; the unit does not enforce this.
module codon_to_amino_translator_unit #(
  parameter int POSITION_BITS = cta_pkg::POSITION_BITS_DEF,
  parameter int QUEUE_DEPTH   = cta_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cta_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cta_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cta_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     base_char_i,
  input  logic                           last_base_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     amino_char_o,
  output logic                           is_stop_o
);
  import cta_pkg::*;

  logic [CFG_W-1:0] frame_start_q;
  logic             cfg_write;
  logic             push;
  logic             pop;
  logic             queue_full;
  logic             queue_valid;
  codon_t           push_codon;
  codon_t           pop_codon;

  // Register port: word index is the upper address bit.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[APB_ADDR_W-1] == REG_FRAME_START)
                   ? APB_DATA_W'(frame_start_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_start_q <= FRAME_START_RESET;
    end else if (cfg_write && (paddr[APB_ADDR_W-1] == REG_FRAME_START)) begin
      frame_start_q <= pwdata[CFG_W-1:0];
    end
  end

  cta_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .base_char_i   (base_char_i),
    .last_base_i   (last_base_i),
    .frame_start_i (frame_start_q),
    .queue_full_i  (queue_full),
    .in_stall_o    (in_stall_o),
    .push_o        (push),
    .codon_o       (push_codon)
  );

  cta_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_codon),
    .pop_i       (pop),
    .full_o      (queue_full),
    .valid_o     (queue_valid),
    .pop_data_o  (pop_codon)
  );

  cta_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_valid_i (queue_valid),
    .codon_i       (pop_codon),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .amino_char_o  (amino_char_o),
    .is_stop_o     (is_stop_o)
  );

endmodule

// ===== sv/cta_checker.sv =====
// Port-level checker of the codon translator and its bind to the top level.
// Depends on cta_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cta_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [cta_pkg::APB_ADDR_W-1:0] paddr,
  input logic [cta_pkg::APB_DATA_W-1:0] pwdata,
  input logic [cta_pkg::APB_DATA_W-1:0] prdata,
  input logic                           pready,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [7:0]                     amino_char_o,
  input logic                           is_stop_o
);
  import cta_pkg::*;

  // A stalled result stays valid and unchanged.
  `CTA_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(amino_char_o) && $stable(is_stop_o)))

  // A stop result always carries the stop letter.
  `CTA_ASSERT(a_stop_letter, clk_i, rst_ni, (out_valid_o && is_stop_o) |-> (amino_char_o == CHAR_STOP))

  // A stop letter is never given without the stop flag.
  `CTA_ASSERT(a_letter_stop, clk_i, rst_ni, (out_valid_o && (amino_char_o == CHAR_STOP)) |-> is_stop_o)

  // A register write reads back its low half in the next cycle.
  `CTA_ASSERT(a_cfg_readback, clk_i, rst_ni, (psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_FRAME_START)) |=> (paddr[APB_ADDR_W-1] != REG_FRAME_START || prdata == APB_DATA_W'($past(pwdata[CFG_W-1:0]))))

  // The register port never inserts wait states.
  `CTA_ASSERT_ALWAYS(a_pready, clk_i, pready)

endmodule

bind codon_to_amino_translator_unit cta_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata),
  .pready       (pready),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .amino_char_o (amino_char_o),
  .is_stop_o    (is_stop_o)
);
